### hdl/tcw_pkg.sv
// Shared constants and types for the text console writer.
package tcw_pkg;

    // Field widths of the stream payloads
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int RADDR_W    = 11;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;
    localparam int CELL_W     = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;
    localparam int FILL_W     = 8;

    // Operation codes carried in s_axis_tuser
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'h20;

    // Cell contents after reset: space in the reset fill attribute
    localparam logic [FILL_W-1:0] FILL_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL = {FILL_RESET, SPACE_CODE};

    // Configuration register indexes
    localparam int REG_FILL_ATTRIBUTE = 0;

    // Enables of the cell memory ports
    typedef struct packed {
        logic we;
        logic re;
    } mem_en_t;

endpackage

### hdl/text_console_writer_unit.sv
// Top level of the text console writer: stream ports, register port, sequencer.
//
//  channel   | direction | carries
//  s_axis    | in        | one put or read item per transfer
//  m_axis    | out       | one result per item: cursor, scroll flag, cell
//  APB       | in/out    | fill_attribute at byte address 0
//
// A put or a read first updates the cursor and accesses the cell store, then
// loads the result register. A put that scrolls also moves the cells up a row
// and blanks the bottom row, moving one cell per cycle through the single write
// port of the store. After reset a clearing pass fills the store while
// s_axis_tready stays low. A new item is taken while an earlier result still
// waits on m_axis.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // character[7:0], text_color[11:8], back_color[15:12], read_address[26:16]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // operation[0]
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // cursor_column[6:0], cursor_row[11:7], scrolled[12], cell_data[28:13]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic                 reg_hit;
    logic [OUT_COL_W-1:0] res_col;
    logic [OUT_ROW_W-1:0] res_row;
    logic                 res_scr;
    logic [CELL_W-1:0]    res_cell;

    assign pready  = 1'b1;
    assign reg_hit = (32'(paddr[2]) == REG_FILL_ATTRIBUTE);

    always_comb begin
        fill_next = fill_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            fill_next = pwdata[FILL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= FILL_RESET;
        end else begin
            fill_reg <= fill_next;
        end
    end

    assign prdata = reg_hit ? {{(32-FILL_W){1'b0}}, fill_reg} : '0;

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fill_attr    (fill_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_op        (s_axis_tuser),
        .in_char      (s_axis_tdata[7:0]),
        .in_fg        (s_axis_tdata[11:8]),
        .in_bg        (s_axis_tdata[15:12]),
        .in_raddr     (s_axis_tdata[26:16]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_col      (res_col),
        .out_row      (res_row),
        .out_scrolled (res_scr),
        .out_cell     (res_cell)
    );

    assign m_axis_tdata = {3'b000, res_cell, res_scr, res_row, res_col};

endmodule

### hdl/tcw_cell_mem.sv
// Cell store: one write port, one registered read port.
module tcw_cell_mem
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic              aclk,
    input  mem_en_t           en,
    input  logic [AW-1:0]     waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en.we) begin
            mem[waddr] <= wdata;
        end
        if (en.re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/tcw_seq.sv
// Sequencer: cursor, put and read handling, scroll copy, clearing pass, result register.
module tcw_seq
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [FILL_W-1:0]    fill_attr,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_op,
    input  logic [CHAR_W-1:0]    in_char,
    input  logic [COLOR_W-1:0]   in_fg,
    input  logic [COLOR_W-1:0]   in_bg,
    input  logic [RADDR_W-1:0]   in_raddr,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_COL_W-1:0] out_col,
    output logic [OUT_ROW_W-1:0] out_row,
    output logic                 out_scrolled,
    output logic [CELL_W-1:0]    out_cell
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int AW     = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COPY_N = CELLS - COLUMNS;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_COPY   = 5'b00100,
        ST_BLANK  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   line_reg, line_next;
    logic               scr_reg, scr_next;
    logic               rd_sel_reg, rd_sel_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_COL_W-1:0] out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;
    logic               out_scr_reg, out_scr_next;
    logic [CELL_W-1:0]  out_cell_reg, out_cell_next;

    mem_en_t            mem_en;
    logic [AW-1:0]      mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [CELL_W-1:0]  mem_rdata;

    logic [AW-1:0]      cur_lin;
    logic [COL_W:0]     ncol;
    logic [ROW_W:0]     nline;
    logic               raddr_ok;
    logic [CELL_W-1:0]  blank;

    tcw_cell_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .en    (mem_en),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cur_lin  = AW'(32'(line_reg) * 32'(COLUMNS) + 32'(col_reg));
    assign raddr_ok = 32'(in_raddr) < 32'(CELLS);
    assign blank    = {fill_attr, SPACE_CODE};
    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        scr_next       = scr_reg;
        rd_sel_next    = rd_sel_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_scr_next   = out_scr_reg;
        out_cell_next  = out_cell_reg;
        mem_en         = '0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = '0;
        ncol           = {1'b0, col_reg};
        nline          = {1'b0, line_reg};

        unique case (state_reg)
            ST_CLEAR: begin
                mem_en.we = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = RESET_CELL;
                if (ptr_reg == AW'(CELLS - 1)) begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    scr_next    = 1'b0;
                    rd_sel_next = 1'b0;
                    state_next  = ST_FINISH;
                    if (in_op == OP_READ) begin
                        rd_sel_next = raddr_ok;
                        mem_en.re   = raddr_ok;
                        mem_raddr   = AW'(in_raddr);
                    end else begin
                        priority if (in_char == CODE_RETURN) begin
                            ncol = '0;
                        end else if (in_char == CODE_NEWLINE) begin
                            ncol  = '0;
                            nline = nline + 1'b1;
                        end else if (in_char == CODE_BACKSPACE) begin
                            mem_en.we = 1'b1;
                            mem_waddr = (cur_lin == '0) ? '0 : cur_lin - 1'b1;
                            mem_wdata = blank;
                            if (col_reg != '0) begin
                                ncol = ncol - 1'b1;
                            end else if (line_reg != '0) begin
                                nline = nline - 1'b1;
                                ncol  = (COL_W+1)'(COLUMNS - 1);
                            end
                        end else if (in_char >= SPACE_CODE && !in_char[CHAR_W-1]) begin
                            mem_en.we = 1'b1;
                            mem_waddr = cur_lin;
                            mem_wdata = {in_bg, in_fg, in_char};
                            ncol      = ncol + 1'b1;
                        end else begin
                            ncol = {1'b0, col_reg};
                        end
                        // wrap past the last column
                        if (ncol >= (COL_W+1)'(COLUMNS)) begin
                            ncol  = '0;
                            nline = nline + 1'b1;
                        end
                        // past the bottom row: hold on it and scroll
                        if (nline >= (ROW_W+1)'(ROWS)) begin
                            nline      = (ROW_W+1)'(ROWS - 1);
                            scr_next   = 1'b1;
                            ptr_next   = '0;
                            state_next = ST_COPY;
                        end
                        col_next  = ncol[COL_W-1:0];
                        line_next = nline[ROW_W-1:0];
                    end
                end
            end
            ST_COPY: begin
                // write back the cell read in the previous cycle from one row further down
                mem_en.we = (ptr_reg != '0);
                mem_waddr = ptr_reg - 1'b1;
                mem_wdata = mem_rdata;
                mem_en.re = (ptr_reg != AW'(COPY_N));
                mem_raddr = ptr_reg + AW'(COLUMNS);
                if (ptr_reg == AW'(COPY_N)) begin
                    state_next = ST_BLANK;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_BLANK: begin
                mem_en.we = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = blank;
                if (ptr_reg == AW'(CELLS - 1)) begin
                    ptr_next   = '0;
                    state_next = ST_FINISH;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_col_next   = OUT_COL_W'(col_reg);
                    out_row_next   = OUT_ROW_W'(line_reg);
                    out_scr_next   = scr_reg;
                    out_cell_next  = rd_sel_reg ? mem_rdata : '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            col_reg       <= '0;
            line_reg      <= '0;
            scr_reg       <= 1'b0;
            rd_sel_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            scr_reg       <= scr_next;
            rd_sel_reg    <= rd_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_scr_reg  <= out_scr_next;
        out_cell_reg <= out_cell_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_col      = out_col_reg;
    assign out_row      = out_row_reg;
    assign out_scrolled = out_scr_reg;
    assign out_cell     = out_cell_reg;

endmodule

### dv/tb_text_console_writer_unit.sv
// Self-checking testbench for the text console writer: stream items in, cursor and cell results out.
module tb_text_console_writer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int IDX_W       = $clog2(CELLS);
    localparam int ADDR_SPAN   = 1 << RADDR_W;
    localparam logic [CHAR_W-1:0] PRINT_LAST = 8'h7F;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic               op;
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [RADDR_W-1:0] addr;
    } console_item_t;

    typedef struct {
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic                 scrolled;
        logic [CELL_W-1:0]    cell_word;
    } console_result_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = OP_PUT;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [2:0]           paddr         = '0;
    logic [31:0]          pwdata        = '0;
    logic [31:0]          prdata;
    logic                 pready;

    text_console_writer_unit #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Console state as the block should hold it
    logic [CELL_W-1:0] screen_cells [CELLS];
    logic [FILL_W-1:0] fill_attr = FILL_RESET;
    int                cur_col   = 0;
    int                cur_row   = 0;

    console_item_t     items_pending [$];
    console_result_t   results_due   [$];
    int                error_count   = 0;
    int                idle_pct      = 31;
    logic              hold_go       = 1'b0;
    logic              hold_done     = 1'b0;
    int                hold_left     = 0;
    int                cycle_count   = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [CELL_W-1:0] blank_cell();
        return {fill_attr, SPACE_CODE};
    endfunction

    function automatic console_result_t console_apply(console_item_t it);
        console_result_t r;
        int              lin;
        r.scrolled  = 1'b0;
        r.cell_word = '0;
        if (it.op == OP_READ) begin
            if (it.addr < CELLS) r.cell_word = screen_cells[it.addr];
        end else begin
            if (it.ch == CODE_RETURN) begin
                cur_col = 0;
            end else if (it.ch == CODE_NEWLINE) begin
                cur_col = 0;
                cur_row++;
            end else if (it.ch == CODE_BACKSPACE) begin
                lin = cur_row * COLUMNS + cur_col;
                if (lin > 0) lin--;
                if (cur_col > 0) begin
                    cur_col--;
                end else if (cur_row > 0) begin
                    cur_row--;
                    cur_col = COLUMNS - 1;
                end
                screen_cells[IDX_W'(lin)] = blank_cell();
            end else if (it.ch >= SPACE_CODE && it.ch <= PRINT_LAST) begin
                screen_cells[IDX_W'(cur_row * COLUMNS + cur_col)] = {it.bg, it.fg, it.ch};
                cur_col++;
            end
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                cur_row++;
            end
            // scroll: shift rows up, blank the bottom row
            if (cur_row >= ROWS) begin
                for (int k = 0; k < CELLS - COLUMNS; k++)
                    screen_cells[IDX_W'(k)] = screen_cells[IDX_W'(k + COLUMNS)];
                for (int k = CELLS - COLUMNS; k < CELLS; k++)
                    screen_cells[IDX_W'(k)] = blank_cell();
                cur_row    = ROWS - 1;
                r.scrolled = 1'b1;
            end
        end
        r.col = cur_col[OUT_COL_W-1:0];
        r.row = cur_row[OUT_ROW_W-1:0];
        return r;
    endfunction

    function automatic console_item_t make_item(logic op, logic [CHAR_W-1:0] ch,
                                                logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg,
                                                logic [RADDR_W-1:0] addr);
        console_item_t it;
        it.op   = op;
        it.ch   = ch;
        it.fg   = fg;
        it.bg   = bg;
        it.addr = addr;
        return it;
    endfunction

    function automatic console_item_t random_item();
        console_item_t it;
        int            k;
        int            m;
        it = make_item(OP_PUT, CHAR_W'($urandom_range(255)), COLOR_W'($urandom_range(15)),
                       COLOR_W'($urandom_range(15)), RADDR_W'($urandom_range(ADDR_SPAN - 1)));
        k = $urandom_range(99);
        if (k < 30) begin
            it.op = OP_READ;
            m = $urandom_range(9);
            // favor the bottom rows, where the cursor lives once scrolling starts
            if (m < 4)
                it.addr = RADDR_W'($urandom_range(CELLS - 1, CELLS - 3 * COLUMNS));
            else if (m < 8)
                it.addr = RADDR_W'($urandom_range(CELLS - 1));
            else if (m < 9)
                it.addr = RADDR_W'($urandom_range(3 * COLUMNS - 1));
            else
                it.addr = RADDR_W'($urandom_range(ADDR_SPAN - 1, CELLS));
        end else if (k < 73) begin
            it.ch = CHAR_W'($urandom_range(PRINT_LAST, SPACE_CODE));
        end else if (k < 79) begin
            it.ch = CODE_NEWLINE;
        end else if (k < 83) begin
            it.ch = CODE_RETURN;
        end else if (k < 91) begin
            it.ch = CODE_BACKSPACE;
        end else begin
            while ((it.ch >= SPACE_CODE && it.ch <= PRINT_LAST) || it.ch == CODE_BACKSPACE ||
                   it.ch == CODE_NEWLINE || it.ch == CODE_RETURN)
                it.ch = CHAR_W'($urandom_range(255));
        end
        return it;
    endfunction

    // Sender: offer pending items, predict each accepted transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                results_due.push_back(console_apply(make_item(s_axis_tuser, s_axis_tdata[7:0],
                    s_axis_tdata[11:8], s_axis_tdata[15:12], s_axis_tdata[26:16])));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (items_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    console_item_t it;
                    it = items_pending.pop_front();
                    s_axis_tdata  <= {5'b0, it.addr, it.bg, it.fg, it.ch};
                    s_axis_tuser  <= it.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result transfer, stall at random or for one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, 0);
                end else begin
                    console_result_t want;
                    want = results_due.pop_front();
                    if (m_axis_tdata[6:0] !== want.col)
                        report_mismatch("cursor_column", 32'(m_axis_tdata[6:0]), 32'(want.col));
                    if (m_axis_tdata[11:7] !== want.row)
                        report_mismatch("cursor_row", 32'(m_axis_tdata[11:7]), 32'(want.row));
                    if (m_axis_tdata[12] !== want.scrolled)
                        report_mismatch("scrolled", 32'(m_axis_tdata[12]), 32'(want.scrolled));
                    if (m_axis_tdata[28:13] !== want.cell_word)
                        report_mismatch("cell_data", 32'(m_axis_tdata[28:13]),
                                        32'(want.cell_word));
                end
            end
            if (hold_go && !hold_done) begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        @(negedge aclk);
        while (items_pending.size() > 0 || s_axis_tvalid || results_due.size() > 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_fill(input logic [FILL_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_FILL_ATTRIBUTE * 4);
        pwdata  <= {24'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        fill_attr = value;
        @(negedge aclk);
    endtask

    task automatic run_random(input int count, input int idle, input bit with_hold);
        @(negedge aclk);
        idle_pct = idle;
        for (int n = 0; n < count; n++) items_pending.push_back(random_item());
        if (with_hold) hold_go = 1'b1;
        wait_drained();
    endtask

    initial begin
        for (int k = 0; k < CELLS; k++) screen_cells[IDX_W'(k)] = RESET_CELL;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        items_pending.push_back(make_item(OP_PUT, CODE_BACKSPACE, 0, 0, 0));   // backspace at home
        items_pending.push_back(make_item(OP_READ, 0, 0, 0, 0));
        items_pending.push_back(make_item(OP_PUT, SPACE_CODE, 0, 0, 0));
        items_pending.push_back(make_item(OP_PUT, PRINT_LAST, 15, 15, RADDR_W'(ADDR_SPAN - 1)));
        items_pending.push_back(make_item(OP_READ, 8'hFF, 15, 15, 1));
        items_pending.push_back(make_item(OP_READ, 0, 0, 0, 0));
        items_pending.push_back(make_item(OP_PUT, 8'h00, 3, 4, 0));            // ignored codes
        items_pending.push_back(make_item(OP_PUT, 8'h1F, 3, 4, 0));
        items_pending.push_back(make_item(OP_PUT, 8'h80, 3, 4, 0));
        items_pending.push_back(make_item(OP_PUT, 8'hFF, 3, 4, 0));
        items_pending.push_back(make_item(OP_PUT, 8'h09, 3, 4, 0));
        items_pending.push_back(make_item(OP_PUT, CODE_RETURN, 0, 0, 0));
        items_pending.push_back(make_item(OP_PUT, 8'h41, 5, 10, 0));
        items_pending.push_back(make_item(OP_READ, 0, 0, 0, 0));
        items_pending.push_back(make_item(OP_PUT, CODE_NEWLINE, 0, 0, 0));
        items_pending.push_back(make_item(OP_PUT, CODE_BACKSPACE, 0, 0, 0));   // back to last column
        items_pending.push_back(make_item(OP_READ, 0, 0, 0, RADDR_W'(COLUMNS - 1)));
        items_pending.push_back(make_item(OP_PUT, 8'h7A, 12, 6, 0));           // wraps the column
        items_pending.push_back(make_item(OP_READ, 0, 0, 0, RADDR_W'(COLUMNS - 1)));
        items_pending.push_back(make_item(OP_READ, 0, 0, 0, RADDR_W'(CELLS - 1)));
        items_pending.push_back(make_item(OP_READ, 0, 0, 0, RADDR_W'(CELLS)));  // out of range
        items_pending.push_back(make_item(OP_READ, 0, 0, 0, RADDR_W'(ADDR_SPAN - 1)));
        items_pending.push_back(make_item(OP_READ, 0, 0, 0, RADDR_W'(ADDR_SPAN / 2)));
        wait_drained();

        write_fill(8'h00);
        run_random(400, 31, 1'b0);
        write_fill(8'hFF);
        run_random(400, 31, 1'b1);
        write_fill(FILL_W'($urandom_range(8'hFE, 8'h01)));
        run_random(330, 0, 1'b0);

        repeat (20) @(negedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
hdl/tcw_pkg.sv
hdl/tcw_cell_mem.sv
hdl/tcw_seq.sv
hdl/text_console_writer_unit.sv
dv/tb_text_console_writer_unit.sv
